/* sv/cts_pkg.sv */
// Package for the token scanner: token kind codes, byte constants, scan mode
// type, token and scan-result structs, character class functions.
// No dependencies.
`timescale 1ns / 1ps

package cts_pkg;

    localparam int TEXT_BYTES_DEF = 8;
    localparam int OUT_DEPTH_DEF  = 4;
    localparam int TEXT_W         = 64;

    // token kinds
    localparam logic [4:0] K_STOP   = 5'd0;
    localparam logic [4:0] K_NUMBER = 5'd1;
    localparam logic [4:0] K_IDENT  = 5'd2;
    localparam logic [4:0] K_INT    = 5'd3;
    localparam logic [4:0] K_IF     = 5'd4;
    localparam logic [4:0] K_ELSE   = 5'd5;
    localparam logic [4:0] K_WHILE  = 5'd6;
    localparam logic [4:0] K_RETURN = 5'd7;
    localparam logic [4:0] K_PLUS   = 5'd8;
    localparam logic [4:0] K_MINUS  = 5'd9;
    localparam logic [4:0] K_STAR   = 5'd10;
    localparam logic [4:0] K_SLASH  = 5'd11;
    localparam logic [4:0] K_LPAREN = 5'd12;
    localparam logic [4:0] K_RPAREN = 5'd13;
    localparam logic [4:0] K_LBRACE = 5'd14;
    localparam logic [4:0] K_RBRACE = 5'd15;
    localparam logic [4:0] K_SEMI   = 5'd16;
    localparam logic [4:0] K_COMMA  = 5'd17;
    localparam logic [4:0] K_ASSIGN = 5'd18;
    localparam logic [4:0] K_EQ     = 5'd19;
    localparam logic [4:0] K_NE     = 5'd20;
    localparam logic [4:0] K_LT     = 5'd21;
    localparam logic [4:0] K_LE     = 5'd22;
    localparam logic [4:0] K_GT     = 5'd23;
    localparam logic [4:0] K_GE     = 5'd24;
    localparam logic [4:0] K_LAST   = K_GE;

    // bytes
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_US   = 8'h5F;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UZ   = 8'h5A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    // keyword text, first char in low byte
    localparam logic [63:0] KW_INT    = 64'h746E69;
    localparam logic [63:0] KW_IF     = 64'h6669;
    localparam logic [63:0] KW_ELSE   = 64'h65736C65;
    localparam logic [63:0] KW_WHILE  = 64'h656C696877;
    localparam logic [63:0] KW_RETURN = 64'h6E7275746572;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_NUM   = 7'b0000010,
        M_IDENT = 7'b0000100,
        M_EQ    = 7'b0001000,
        M_BANG  = 7'b0010000,
        M_LT    = 7'b0100000,
        M_GT    = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [4:0]        token_kind;
        logic [31:0]       number_value;
        logic [TEXT_W-1:0] text_bytes;
        logic [7:0]        text_length;
        logic              last_of_run;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_scan_res;

    localparam t_token STOP_TOKEN = '0;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alp(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || (c == CH_US);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // single-char punctuation: {hit, kind}
    function automatic logic [5:0] punct_lookup(input logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            8'h2B:   r = {1'b1, K_PLUS};
            8'h2D:   r = {1'b1, K_MINUS};
            8'h2A:   r = {1'b1, K_STAR};
            8'h2F:   r = {1'b1, K_SLASH};
            8'h28:   r = {1'b1, K_LPAREN};
            8'h29:   r = {1'b1, K_RPAREN};
            8'h7B:   r = {1'b1, K_LBRACE};
            8'h7D:   r = {1'b1, K_RBRACE};
            8'h3B:   r = {1'b1, K_SEMI};
            8'h2C:   r = {1'b1, K_COMMA};
            default: r = {1'b0, K_STOP};
        endcase
        return r;
    endfunction

endpackage

/* sv/cts_if.sv */
// Handshake channels of the token scanner: source bytes in, tokens out.
// No dependencies.
`timescale 1ns / 1ps

interface cts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       is_end;

    modport source (output valid, output char_byte, output is_end, input ready);
    modport sink   (input valid, input char_byte, input is_end, output ready);
endinterface

interface cts_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [31:0] number_value;
    logic [63:0] text_bytes;
    logic [7:0]  text_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output number_value,
                    output text_bytes, output text_length, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input number_value,
                    input text_bytes, input text_length, input last_of_run,
                    output ready);
endinterface

/* sv/cts_scan_core.sv */
// Scanner state (mode, pending text, count, number) and the per-byte
// next-state / token logic; emits up to two tokens per transfer. Uses cts_pkg.
`timescale 1ns / 1ps

module cts_scan_core #(
    parameter int TEXT_BYTES = cts_pkg::TEXT_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_char_byte,
    input  logic                 i_is_end,
    output cts_pkg::t_scan_res   o_res
);

    localparam int SW = TEXT_BYTES * 8;

    cts_pkg::t_mode    r_mode,  n_mode;
    logic [SW-1:0]     r_store, n_store;
    logic [7:0]        r_count, n_count;
    logic [31:0]       r_accum, n_accum;

    logic [63:0]       text64;
    logic [SW-1:0]     app_store;
    logic [7:0]        app_count;
    logic [4:0]        id_kind;
    logic              flush_v;
    cts_pkg::t_token   flush_tok;
    logic              idle_v;
    cts_pkg::t_token   idle_tok;
    logic [5:0]        pl;
    logic              done;
    cts_pkg::t_token   t0, t1;
    logic [1:0]        nres;

    assign text64 = 64'(r_store);

    // append current byte to pending text
    always_comb begin
        app_store = r_store;
        for (int b = 0; b < TEXT_BYTES; b++) begin
            if (r_count == 8'(b)) begin
                app_store[b*8 +: 8] = i_char_byte;
            end
        end
        app_count = (r_count == 8'hFF) ? r_count : r_count + 8'd1;
    end

    always_comb begin
        priority if (r_count == 8'd3 && text64 == cts_pkg::KW_INT) begin
            id_kind = cts_pkg::K_INT;
        end else if (r_count == 8'd2 && text64 == cts_pkg::KW_IF) begin
            id_kind = cts_pkg::K_IF;
        end else if (r_count == 8'd4 && text64 == cts_pkg::KW_ELSE) begin
            id_kind = cts_pkg::K_ELSE;
        end else if (r_count == 8'd5 && text64 == cts_pkg::KW_WHILE) begin
            id_kind = cts_pkg::K_WHILE;
        end else if (r_count == 8'd6 && text64 == cts_pkg::KW_RETURN) begin
            id_kind = cts_pkg::K_RETURN;
        end else begin
            id_kind = cts_pkg::K_IDENT;
        end
    end

    // token left pending by the current mode
    always_comb begin
        flush_v   = 1'b1;
        flush_tok = cts_pkg::STOP_TOKEN;
        unique case (r_mode)
            cts_pkg::M_NUM: begin
                flush_tok = '{cts_pkg::K_NUMBER, r_accum, text64, r_count, 1'b0};
            end
            cts_pkg::M_IDENT: begin
                flush_tok = '{id_kind, 32'd0, text64, r_count, 1'b0};
            end
            cts_pkg::M_EQ: begin
                flush_tok = '{cts_pkg::K_ASSIGN, 32'd0, 64'(cts_pkg::CH_EQ), 8'd1, 1'b0};
            end
            cts_pkg::M_BANG: begin
                flush_tok = cts_pkg::STOP_TOKEN;
            end
            cts_pkg::M_LT: begin
                flush_tok = '{cts_pkg::K_LT, 32'd0, 64'(cts_pkg::CH_LT), 8'd1, 1'b0};
            end
            cts_pkg::M_GT: begin
                flush_tok = '{cts_pkg::K_GT, 32'd0, 64'(cts_pkg::CH_GT), 8'd1, 1'b0};
            end
            default: begin
                flush_v = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_store = r_store;
        n_count = r_count;
        n_accum = r_accum;
        t0      = cts_pkg::STOP_TOKEN;
        t1      = cts_pkg::STOP_TOKEN;
        nres    = 2'd0;
        done    = 1'b0;
        idle_v  = 1'b0;
        idle_tok = cts_pkg::STOP_TOKEN;
        pl      = cts_pkg::punct_lookup(i_char_byte);

        if (i_is_end) begin
            n_mode  = cts_pkg::M_IDLE;
            n_store = '0;
            n_count = '0;
            n_accum = '0;
            if (flush_v) begin
                t0   = flush_tok;
                nres = 2'd2;
            end else begin
                nres = 2'd1;
            end
        end else begin
            // continuation of the pending token
            unique case (r_mode)
                cts_pkg::M_NUM: begin
                    if (cts_pkg::is_dig(i_char_byte)) begin
                        done    = 1'b1;
                        n_accum = (r_accum << 3) + (r_accum << 1)
                                + 32'(i_char_byte - cts_pkg::CH_0);
                        n_store = app_store;
                        n_count = app_count;
                    end
                end
                cts_pkg::M_IDENT: begin
                    if (cts_pkg::is_alp(i_char_byte) || cts_pkg::is_dig(i_char_byte)) begin
                        done    = 1'b1;
                        n_store = app_store;
                        n_count = app_count;
                    end
                end
                cts_pkg::M_EQ, cts_pkg::M_BANG, cts_pkg::M_LT, cts_pkg::M_GT: begin
                    if (i_char_byte == cts_pkg::CH_EQ) begin
                        done    = 1'b1;
                        nres    = 2'd1;
                        n_mode  = cts_pkg::M_IDLE;
                        n_store = '0;
                        n_count = '0;
                        n_accum = '0;
                        t0.text_bytes  = 64'({cts_pkg::CH_EQ, cts_pkg::CH_EQ});
                        t0.text_length = 8'd2;
                        unique case (r_mode)
                            cts_pkg::M_EQ:   t0.token_kind = cts_pkg::K_EQ;
                            cts_pkg::M_BANG: begin
                                t0.token_kind = cts_pkg::K_NE;
                                t0.text_bytes = 64'({cts_pkg::CH_EQ, cts_pkg::CH_BANG});
                            end
                            cts_pkg::M_LT: begin
                                t0.token_kind = cts_pkg::K_LE;
                                t0.text_bytes = 64'({cts_pkg::CH_EQ, cts_pkg::CH_LT});
                            end
                            default: begin
                                t0.token_kind = cts_pkg::K_GE;
                                t0.text_bytes = 64'({cts_pkg::CH_EQ, cts_pkg::CH_GT});
                            end
                        endcase
                    end
                end
                default: begin
                    done = 1'b0;
                end
            endcase

            if (!done) begin
                // flush, then scan this byte from idle
                n_mode  = cts_pkg::M_IDLE;
                n_store = '0;
                n_count = '0;
                n_accum = '0;
                priority if (cts_pkg::is_space(i_char_byte)) begin
                    idle_v = 1'b0;
                end else if (cts_pkg::is_dig(i_char_byte)) begin
                    n_mode  = cts_pkg::M_NUM;
                    n_accum = 32'(i_char_byte - cts_pkg::CH_0);
                    n_store = SW'(i_char_byte);
                    n_count = 8'd1;
                end else if (cts_pkg::is_alp(i_char_byte)) begin
                    n_mode  = cts_pkg::M_IDENT;
                    n_store = SW'(i_char_byte);
                    n_count = 8'd1;
                end else if (pl[5]) begin
                    idle_v   = 1'b1;
                    idle_tok = '{pl[4:0], 32'd0, 64'(i_char_byte), 8'd1, 1'b0};
                end else if (i_char_byte == cts_pkg::CH_EQ) begin
                    n_mode = cts_pkg::M_EQ;
                end else if (i_char_byte == cts_pkg::CH_BANG) begin
                    n_mode = cts_pkg::M_BANG;
                end else if (i_char_byte == cts_pkg::CH_LT) begin
                    n_mode = cts_pkg::M_LT;
                end else if (i_char_byte == cts_pkg::CH_GT) begin
                    n_mode = cts_pkg::M_GT;
                end else begin
                    idle_v   = 1'b1;
                    idle_tok = cts_pkg::STOP_TOKEN;
                end

                if (flush_v) begin
                    t0   = flush_tok;
                    t1   = idle_tok;
                    nres = idle_v ? 2'd2 : 2'd1;
                end else begin
                    t0   = idle_tok;
                    nres = idle_v ? 2'd1 : 2'd0;
                end
            end
        end

        if (nres == 2'd1) begin
            t0.last_of_run = 1'b1;
        end
        if (nres == 2'd2) begin
            t1.last_of_run = 1'b1;
        end
    end

    assign o_res = '{(i_accept ? nres : 2'd0), t0, t1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cts_pkg::M_IDLE;
            r_store <= '0;
            r_count <= '0;
            r_accum <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_store <= n_store;
            r_count <= n_count;
            r_accum <= n_accum;
        end
    end

endmodule

/* sv/cts_out_fifo.sv */
// Small register queue for tokens: takes zero, one or two per cycle,
// hands out one per output transfer. Uses cts_pkg.
`timescale 1ns / 1ps

module cts_out_fifo #(
    parameter int DEPTH = cts_pkg::OUT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cts_pkg::t_scan_res i_push,
    output logic               o_room2,
    output logic               o_valid,
    output cts_pkg::t_token    o_tok,
    input  logic               i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cts_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]   r_wp, n_wp, wp1;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            pop;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop     = i_pop && (r_cnt != '0);
    assign wp1     = inc(r_wp);
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];
    assign o_room2 = (r_cnt <= CW'(DEPTH - 2));

    always_comb begin
        n_wp = r_wp;
        unique case (i_push.count)
            2'd1:    n_wp = wp1;
            2'd2:    n_wp = inc(wp1);
            default: n_wp = r_wp;
        endcase
        n_rp  = pop ? inc(r_rp) : r_rp;
        n_cnt = r_cnt + CW'(i_push.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* sv/c_subset_token_scanner_unit.sv */
// Top level of the C-subset token scanner: scan core plus output token queue.
// Depends on cts_pkg, cts_if, cts_scan_core, cts_out_fifo.
//
// Usage:
//   i_src carries one source byte per transfer (char_byte), or an end item
//   (is_end = 1, char_byte ignored). o_tok carries one token per transfer;
//   last_of_run marks the final token caused by one input transfer. A byte
//   may cause zero, one or two tokens; an end item causes one or two (any
//   pending token, then a stop token).
//   Latency: a token is written to the queue register at its input transfer;
//   it is offered on o_tok in the cycle after if no older token is still queued.
//   Throughput: one input transfer per cycle while the output is taken each
//   cycle and bytes cause at most one token each. Tokens leave at one per
//   cycle, so bytes that cause two tokens fill the 4-entry queue; i_src.ready
//   drops while fewer than two entries are free.
//   Reset (i_rst_n low, synchronous): scanner returns to idle with empty text,
//   count and number; queue is emptied, no token offered.
//   Receiver stall: the head token holds on o_tok until taken; the input side
//   keeps taking bytes until the queue cannot hold another two tokens.
`timescale 1ns / 1ps

module c_subset_token_scanner_unit #(
    parameter int TEXT_BYTES = cts_pkg::TEXT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cts_in_if.sink     i_src,
    cts_out_if.source  o_tok
);

    logic               accept;
    logic               room2;
    cts_pkg::t_scan_res scan_res;
    cts_pkg::t_token    head;

    // ready depends only on queue fill, never on the output ready
    assign i_src.ready = room2;
    assign accept      = i_src.valid && room2;

    cts_scan_core #(
        .TEXT_BYTES (TEXT_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_byte (i_src.char_byte),
        .i_is_end    (i_src.is_end),
        .o_res       (scan_res)
    );

    cts_out_fifo #(
        .DEPTH (cts_pkg::OUT_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (scan_res),
        .o_room2 (room2),
        .o_valid (o_tok.valid),
        .o_tok   (head),
        .i_pop   (o_tok.ready)
    );

    assign o_tok.token_kind   = head.token_kind;
    assign o_tok.number_value = head.number_value;
    assign o_tok.text_bytes   = head.text_bytes;
    assign o_tok.text_length  = head.text_length;
    assign o_tok.last_of_run  = head.last_of_run;

endmodule

/* sv/cts_checker.sv */
// Port-level checks of the token scanner and their bind to the top level.
// Depends on cts_pkg and c_subset_token_scanner_unit.
`timescale 1ns / 1ps

module cts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_kind,
    input logic [31:0] i_value,
    input logic [7:0]  i_length
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("token withdrawn while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token offered right after reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_kind <= cts_pkg::K_LAST)
        else $error("token kind out of range");

    a_stop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_kind == cts_pkg::K_STOP) == (i_length == 8'd0)))
        else $error("stop token and empty text disagree");

    a_num_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind != cts_pkg::K_NUMBER) |-> i_value == 32'd0)
        else $error("value on a non-number token");

endmodule

bind c_subset_token_scanner_unit cts_checker u_cts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_kind      (o_tok.token_kind),
    .i_value     (o_tok.number_value),
    .i_length    (o_tok.text_length)
);

/* bench/tb_c_subset_token_scanner_unit.sv */
// Testbench for c_subset_token_scanner_unit: streams source bytes and end items,
// predicts every token in a local scanner model and checks each output transfer.
// Depends on cts_pkg, cts_if and the scanner RTL.
`timescale 1ns / 1ps

module tb_c_subset_token_scanner_unit;

    localparam int KEEP_BYTES = cts_pkg::TEXT_BYTES_DEF;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         calm;   // no gaps on either side while this byte is sent
        bit         drain;  // hold this byte back until all tokens are out
    } t_src_item;

    logic i_clk;
    logic i_rst_n;

    cts_in_if  src_bus ();
    cts_out_if tok_bus ();

    c_subset_token_scanner_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_bus),
        .o_tok   (tok_bus)
    );

    // byte stream still to send, and tokens still to come out
    t_src_item       byte_plan[$];
    cts_pkg::t_token expected_tokens[$];
    cts_pkg::t_token step_out[$];

    // local scanner state
    cts_pkg::t_mode run_mode;
    logic [63:0]    run_text;
    logic [7:0]     run_len;
    logic [31:0]    run_num;

    int  err_count = 0;
    int  in_count  = 0;
    int  plan_total;
    bit  src_took, tok_took;
    bit  calm_mode, calm_phase, drain_next;
    bit  sink_hold;
    bit  offering;
    int  gap_left;
    int  sink_wait;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
        err_count++;
    endtask

    // ---------------- token predictor ----------------

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= cts_pkg::CH_0 && c <= cts_pkg::CH_9;
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return (c >= cts_pkg::CH_LA && c <= cts_pkg::CH_LZ)
            || (c >= cts_pkg::CH_UA && c <= cts_pkg::CH_UZ) || c == cts_pkg::CH_US;
    endfunction

    function automatic void clear_run();
        run_mode = cts_pkg::M_IDLE;
        run_text = '0;
        run_len  = '0;
        run_num  = '0;
    endfunction

    function automatic void keep_char(input logic [7:0] c);
        if (run_len < KEEP_BYTES)
            run_text[run_len*8 +: 8] = c;
        if (run_len != 8'd255)
            run_len++;
    endfunction

    function automatic void emit(input logic [4:0] k, input logic [31:0] v,
                                 input logic [63:0] t, input logic [7:0] n);
        cts_pkg::t_token tk;
        tk.token_kind   = k;
        tk.number_value = v;
        tk.text_bytes   = t;
        tk.text_length  = n;
        tk.last_of_run  = 1'b0;
        step_out.push_back(tk);
    endfunction

    function automatic void flush_pending();
        logic [4:0] k;
        case (run_mode)
            cts_pkg::M_NUM: emit(cts_pkg::K_NUMBER, run_num, run_text, run_len);
            cts_pkg::M_IDENT: begin
                // keyword match needs exact length as well as text
                k = cts_pkg::K_IDENT;
                if (run_len == 8'd3 && run_text == cts_pkg::KW_INT) k = cts_pkg::K_INT;
                if (run_len == 8'd2 && run_text == cts_pkg::KW_IF) k = cts_pkg::K_IF;
                if (run_len == 8'd4 && run_text == cts_pkg::KW_ELSE) k = cts_pkg::K_ELSE;
                if (run_len == 8'd5 && run_text == cts_pkg::KW_WHILE) k = cts_pkg::K_WHILE;
                if (run_len == 8'd6 && run_text == cts_pkg::KW_RETURN) k = cts_pkg::K_RETURN;
                emit(k, '0, run_text, run_len);
            end
            cts_pkg::M_EQ:   emit(cts_pkg::K_ASSIGN, '0, {56'd0, cts_pkg::CH_EQ}, 8'd1);
            cts_pkg::M_BANG: emit(cts_pkg::K_STOP, '0, '0, '0);
            cts_pkg::M_LT:   emit(cts_pkg::K_LT, '0, {56'd0, cts_pkg::CH_LT}, 8'd1);
            cts_pkg::M_GT:   emit(cts_pkg::K_GT, '0, {56'd0, cts_pkg::CH_GT}, 8'd1);
            default: ;
        endcase
        clear_run();
    endfunction

    function automatic void scan_step(input logic [7:0] c, input logic fin);
        logic            taken;
        cts_pkg::t_token tk;
        step_out.delete();
        taken = 1'b0;
        if (fin) begin
            flush_pending();
            emit(cts_pkg::K_STOP, '0, '0, '0);
        end else begin
            case (run_mode)
                cts_pkg::M_NUM: if (digit_ch(c)) begin
                    run_num = run_num * 32'd10 + 32'(c - cts_pkg::CH_0);
                    keep_char(c);
                    taken = 1'b1;
                end
                cts_pkg::M_IDENT: if (word_start(c) || digit_ch(c)) begin
                    keep_char(c);
                    taken = 1'b1;
                end
                cts_pkg::M_EQ, cts_pkg::M_BANG, cts_pkg::M_LT, cts_pkg::M_GT:
                if (c == cts_pkg::CH_EQ) begin
                    case (run_mode)
                        cts_pkg::M_EQ:
                            emit(cts_pkg::K_EQ, '0,
                                 {48'd0, cts_pkg::CH_EQ, cts_pkg::CH_EQ}, 8'd2);
                        cts_pkg::M_BANG:
                            emit(cts_pkg::K_NE, '0,
                                 {48'd0, cts_pkg::CH_EQ, cts_pkg::CH_BANG}, 8'd2);
                        cts_pkg::M_LT:
                            emit(cts_pkg::K_LE, '0,
                                 {48'd0, cts_pkg::CH_EQ, cts_pkg::CH_LT}, 8'd2);
                        default:
                            emit(cts_pkg::K_GE, '0,
                                 {48'd0, cts_pkg::CH_EQ, cts_pkg::CH_GT}, 8'd2);
                    endcase
                    clear_run();
                    taken = 1'b1;
                end
                default: ;
            endcase
            // lookahead byte: emit what was pending, then scan it from idle
            if (!taken) begin
                flush_pending();
                if (c == cts_pkg::CH_SP || c == cts_pkg::CH_TAB || c == cts_pkg::CH_CR
                        || c == cts_pkg::CH_LF) begin
                end else if (digit_ch(c)) begin
                    run_mode = cts_pkg::M_NUM;
                    run_num  = 32'(c - cts_pkg::CH_0);
                    keep_char(c);
                end else if (word_start(c)) begin
                    run_mode = cts_pkg::M_IDENT;
                    keep_char(c);
                end else begin
                    case (c)
                        "+":     emit(cts_pkg::K_PLUS, '0, {56'd0, c}, 8'd1);
                        "-":     emit(cts_pkg::K_MINUS, '0, {56'd0, c}, 8'd1);
                        "*":     emit(cts_pkg::K_STAR, '0, {56'd0, c}, 8'd1);
                        "/":     emit(cts_pkg::K_SLASH, '0, {56'd0, c}, 8'd1);
                        "(":     emit(cts_pkg::K_LPAREN, '0, {56'd0, c}, 8'd1);
                        ")":     emit(cts_pkg::K_RPAREN, '0, {56'd0, c}, 8'd1);
                        "{":     emit(cts_pkg::K_LBRACE, '0, {56'd0, c}, 8'd1);
                        "}":     emit(cts_pkg::K_RBRACE, '0, {56'd0, c}, 8'd1);
                        ";":     emit(cts_pkg::K_SEMI, '0, {56'd0, c}, 8'd1);
                        ",":     emit(cts_pkg::K_COMMA, '0, {56'd0, c}, 8'd1);
                        cts_pkg::CH_EQ:   run_mode = cts_pkg::M_EQ;
                        cts_pkg::CH_BANG: run_mode = cts_pkg::M_BANG;
                        cts_pkg::CH_LT:   run_mode = cts_pkg::M_LT;
                        cts_pkg::CH_GT:   run_mode = cts_pkg::M_GT;
                        default: emit(cts_pkg::K_STOP, '0, '0, '0);  // unknown byte
                    endcase
                end
            end
        end
        for (int i = 0; i < step_out.size(); i++) begin
            tk = step_out[i];
            tk.last_of_run = (i == step_out.size() - 1);
            expected_tokens.push_back(tk);
        end
    endfunction

    // ---------------- stimulus plan ----------------

    task automatic plan_byte(input logic [7:0] c, input logic fin);
        t_src_item it;
        it.ch    = c;
        it.fin   = fin;
        it.calm  = calm_phase;
        it.drain = drain_next;
        drain_next = 1'b0;
        byte_plan.push_back(it);
    endtask

    task automatic plan_text(input string s);
        for (int i = 0; i < s.len(); i++)
            plan_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0:       return cts_pkg::CH_SP;
            1:       return cts_pkg::CH_TAB;
            2:       return cts_pkg::CH_CR;
            default: return cts_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 8))
            0:       return cts_pkg::CH_US;
            1, 2, 3: return cts_pkg::CH_UA + 8'($urandom_range(0, 25));
            default: return cts_pkg::CH_LA + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rand_word_char();
        if ($urandom_range(0, 3) == 0)
            return cts_pkg::CH_0 + 8'($urandom_range(0, 9));
        return rand_letter();
    endfunction

    // one well-formed token mostly; some noise, end items and broken operators
    task automatic plan_random_token();
        string kw_text [5] = '{"int", "if", "else", "while", "return"};
        string op_text [8] = '{"=", "==", "!=", "<", "<=", ">", ">=", "!"};
        string punct_chars = "+-*/(){};,";
        int    r, len;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            plan_text(kw_text[$urandom_range(0, 4)]);
            if ($urandom_range(0, 3) == 0)
                plan_byte(rand_word_char(), 1'b0);
        end else if (r < 40) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            plan_byte(rand_letter(), 1'b0);
            for (int i = 1; i < len; i++)
                plan_byte(rand_word_char(), 1'b0);
        end else if (r < 55) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                plan_byte(cts_pkg::CH_0 + 8'($urandom_range(0, 9)), 1'b0);
        end else if (r < 70) begin
            plan_byte(punct_chars[$urandom_range(0, 9)], 1'b0);
        end else if (r < 82) begin
            plan_text(op_text[$urandom_range(0, 7)]);
        end else if (r < 88) begin
            plan_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 92) begin
            plan_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        if ($urandom_range(0, 1) == 0)
            plan_byte(ws_char(), 1'b0);
    endtask

    // ---------------- source driver ----------------

    always @(negedge i_clk) begin : src_drive
        logic      nv;
        t_src_item it;
        if (!i_rst_n) begin
            src_bus.valid <= 1'b0;
            offering = 1'b0;
            gap_left = -1;
        end else begin
            nv = offering;
            if (src_took) begin
                offering = 1'b0;
                nv = 1'b0;
            end
            if (!offering && byte_plan.size() > 0
                    && !(byte_plan[0].drain && expected_tokens.size() != 0)) begin
                if (gap_left < 0)
                    gap_left = byte_plan[0].calm ? 0 : $urandom_range(0, 4);
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    it = byte_plan.pop_front();
                    calm_mode = it.calm;
                    src_bus.char_byte <= it.ch;
                    src_bus.is_end    <= it.fin;
                    offering = 1'b1;
                    nv = 1'b1;
                    gap_left = -1;
                end
            end
            src_bus.valid <= nv;
        end
    end

    // ---------------- token sink ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tok_bus.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (tok_took)
                sink_wait = calm_mode ? 0 : $urandom_range(0, 4);
            if (sink_hold || sink_wait > 0) begin
                if (sink_wait > 0)
                    sink_wait--;
                tok_bus.ready <= 1'b0;
            end else begin
                tok_bus.ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the output queue fills and input stalls
    initial begin
        sink_hold = 1'b0;
        while (in_count < 150) @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (120) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    // ---------------- monitor and checker ----------------

    always @(posedge i_clk) begin : monitor
        cts_pkg::t_token got, want;
        if (!i_rst_n) begin
            clear_run();
            src_took = 1'b0;
            tok_took = 1'b0;
        end else begin
            src_took = src_bus.valid && src_bus.ready;
            tok_took = tok_bus.valid && tok_bus.ready;
            if (src_took) begin
                scan_step(src_bus.char_byte, src_bus.is_end);
                in_count++;
            end
            if (tok_took) begin
                got.token_kind   = tok_bus.token_kind;
                got.number_value = tok_bus.number_value;
                got.text_bytes   = tok_bus.text_bytes;
                got.text_length  = tok_bus.text_length;
                got.last_of_run  = tok_bus.last_of_run;
                if (expected_tokens.size() == 0) begin
                    note_mismatch("token with none pending", '0, 64'(got.token_kind));
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.token_kind !== want.token_kind)
                        note_mismatch("token_kind", 64'(want.token_kind),
                                      64'(got.token_kind));
                    if (got.number_value !== want.number_value)
                        note_mismatch("number_value", 64'(want.number_value),
                                      64'(got.number_value));
                    if (got.text_bytes !== want.text_bytes)
                        note_mismatch("text_bytes", want.text_bytes, got.text_bytes);
                    if (got.text_length !== want.text_length)
                        note_mismatch("text_length", 64'(want.text_length),
                                      64'(got.text_length));
                    if (got.last_of_run !== want.last_of_run)
                        note_mismatch("last_of_run", 64'(want.last_of_run),
                                      64'(got.last_of_run));
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        int next_phase;
        bit long_done;
        i_rst_n           = 1'b0;
        src_bus.valid     = 1'b0;
        src_bus.char_byte = '0;
        src_bus.is_end    = 1'b0;
        tok_bus.ready     = 1'b0;
        calm_mode  = 1'b0;
        calm_phase = 1'b0;
        drain_next = 1'b0;
        next_phase = 200;
        long_done  = 1'b0;

        // directed: operators with lookahead, lone bang, byte extremes,
        // end flushing an ident, end with a bang pending
        plan_text("if(v1<=9)!x=>");
        plan_byte(8'h00, 1'b0);
        plan_byte(8'hFF, 1'b0);
        plan_text("a");
        plan_byte(8'hFF, 1'b1);
        plan_text("!");
        plan_byte(8'h00, 1'b1);

        while (byte_plan.size() < 1300) begin
            if (byte_plan.size() >= next_phase) begin
                calm_phase = ~calm_phase;
                drain_next = 1'b1;
                next_phase += 200;
            end
            // overlong ident and number: truncated text, saturated length, wrap
            if (!long_done && byte_plan.size() >= 500) begin
                plan_byte(rand_letter(), 1'b0);
                for (int i = 0; i < 259; i++)
                    plan_byte(rand_word_char(), 1'b0);
                plan_byte(ws_char(), 1'b0);
                for (int i = 0; i < 270; i++)
                    plan_byte(cts_pkg::CH_0 + 8'($urandom_range(0, 9)), 1'b0);
                plan_byte(cts_pkg::CH_SP, 1'b1);
                long_done = 1'b1;
            end
            plan_random_token();
        end
        plan_byte(cts_pkg::CH_SP, 1'b1);
        plan_total = byte_plan.size();

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (in_count < plan_total || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
